@@ rtl/cst_pkg.sv @@
package cst_pkg;

  // Longest token the limit register may ask for.
  localparam int LIMIT_MAX = 4095;

  // Result queue between the scanner and the output port.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Most results that one input byte can cause.
  localparam int MAX_RES = 3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_BRACKET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_BRACKET = 2'd2;

  // Scanner modes.
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_STRING  = 3'd2;
  localparam logic [2:0] M_ESCAPE  = 3'd3;
  localparam logic [2:0] M_NUMBER  = 3'd4;
  localparam logic [2:0] M_NAME    = 3'd5;
  localparam logic [2:0] M_DASH    = 3'd6;

  // Result event codes.
  localparam logic [1:0] EV_TEXT = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_END  = 2'd2;

  // Token kinds.
  localparam logic [4:0] K_NEWLINE  = 5'd0;
  localparam logic [4:0] K_STAR     = 5'd1;
  localparam logic [4:0] K_COMMA    = 5'd2;
  localparam logic [4:0] K_COLON    = 5'd3;
  localparam logic [4:0] K_EQUALS   = 5'd4;
  localparam logic [4:0] K_OPEN     = 5'd5;
  localparam logic [4:0] K_CLOSE    = 5'd6;
  localparam logic [4:0] K_STRING   = 5'd7;
  localparam logic [4:0] K_NUMBER   = 5'd8;
  localparam logic [4:0] K_NAME     = 5'd9;
  localparam logic [4:0] K_KEYWORD  = 5'd10;
  localparam logic [4:0] K_ERROR    = 5'd22;

  // Error codes.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_EOF_STRING = 2'd1;
  localparam logic [1:0] ERR_DASH       = 2'd2;
  localparam logic [1:0] ERR_BYTE       = 2'd3;

  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [4:0]  token_kind;
    logic [7:0]  text_byte;
    logic [11:0] text_length;
    logic [23:0] line_number;
    logic [1:0]  error_code;
    logic        last_of_item;
  } result_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] tc;
    logic [23:0] line;
    logic [11:0] cand;
  } scan_state_t;

  typedef struct packed {
    logic [11:0] token_limit;
    logic [7:0]  open_bracket;
    logic [7:0]  close_bracket;
  } cfg_t;

endpackage

@@ rtl/cst_step.sv @@
module cst_step import cst_pkg::*; (
  input  cfg_t                      cfg,
  input  scan_state_t               cur,
  input  logic [7:0]                data_byte,
  input  logic                      end_of_input,
  output scan_state_t               nxt,
  output logic [1:0]                res_count,
  output result_t [MAX_RES-1:0]     res
);

  localparam int KW_COUNT = 12;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  typedef struct packed {
    logic [11:0] tc;
    logic [11:0] cand;
    logic        full;
  } append_t;

  // Keyword spelling, first character in the top byte.
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
    logic [63:0] w;
    case (k)
      4'd0:    w = {"group", 24'h0};
      4'd1:    w = {"nodes", 24'h0};
      4'd2:    w = {"node", 32'h0};
      4'd3:    w = {"attrs", 24'h0};
      4'd4:    w = {"attr", 32'h0};
      4'd5:    w = {"value", 24'h0};
      4'd6:    w = {"number", 16'h0};
      4'd7:    w = {"from", 32'h0};
      4'd8:    w = {"to", 48'h0};
      4'd9:    w = {"match", 24'h0};
      4'd10:   w = {"ref", 40'h0};
      4'd11:   w = {"class", 24'h0};
      default: w = 64'h0;
    endcase
    return w[{~p, 3'b000} +: 8];
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [2:0] n;
    case (k)
      4'd2, 4'd4, 4'd7: n = 3'd4;
      4'd6:             n = 3'd6;
      4'd8:             n = 3'd2;
      4'd10:            n = 3'd3;
      default:          n = 3'd5;
    endcase
    return n;
  endfunction

  // Lowest keyword still possible whose length matches, else a plain name.
  function automatic logic [4:0] name_kind(input logic [11:0] cand, input logic [11:0] tc);
    logic [4:0] kind;
    kind = K_NAME;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand[k] && ({9'd0, kw_len(4'(k))} == tc)) begin
        kind = 5'(K_KEYWORD + 5'(k));
      end
    end
    return kind;
  endfunction

  // Adds one text character: keyword mask update, count and limit check.
  function automatic append_t do_append(input logic [11:0] tc, input logic [11:0] cand,
                                        input logic [7:0] c, input logic is_name,
                                        input logic [11:0] lim);
    append_t a;
    a.cand = cand;
    if (is_name) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (!((tc < {9'd0, kw_len(4'(k))}) && (kw_char(4'(k), tc[2:0]) == c))) begin
          a.cand[k] = 1'b0;
        end
      end
    end
    a.tc   = tc + 12'd1;
    a.full = (a.tc >= lim);
    return a;
  endfunction

  function automatic result_t mk(input logic [1:0] ev, input logic [4:0] kind,
                                 input logic [7:0] b, input logic [11:0] len,
                                 input logic [23:0] ln, input logic [1:0] err);
    result_t r;
    r.event_res    = ev;
    r.token_kind   = kind;
    r.text_byte    = b;
    r.text_length  = len;
    r.line_number  = ln;
    r.error_code   = err;
    r.last_of_item = 1'b0;
    return r;
  endfunction

  logic [7:0]  c;
  logic [11:0] lim;
  logic        is_digit;
  logic        is_lower;
  logic        is_letter_or_digit;
  logic [2:0]  mode_v;
  logic [11:0] tc_v;
  logic [23:0] line_v;
  logic [11:0] cand_v;
  logic [1:0]  n;
  logic        reproc;
  append_t     ap;
  result_t [MAX_RES-1:0] res_v;

  assign c        = data_byte;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_lower = (c >= CH_LOW_A) && (c <= CH_LOW_Z);
  assign is_letter_or_digit = is_digit || is_lower;

  // Effective limit: capped, and zero acts as one.
  always_comb begin
    if ({20'd0, cfg.token_limit} > LIMIT_MAX) begin
      lim = 12'(LIMIT_MAX);
    end else if (cfg.token_limit == 12'd0) begin
      lim = 12'd1;
    end else begin
      lim = cfg.token_limit;
    end
  end

  // One scanning step, with the results it causes in order.
  always_comb begin
    mode_v = cur.mode;
    tc_v   = cur.tc;
    line_v = cur.line;
    cand_v = cur.cand;
    n      = 2'd0;
    reproc = 1'b0;
    ap     = '0;
    res_v  = '0;

    case (cur.mode)
      M_COMMENT: begin
        if (end_of_input) begin
          mode_v = M_IDLE;
          res_v[n] = mk(EV_END, K_NEWLINE, 8'd0, 12'd0, line_v, ERR_NONE);
          n = n + 2'd1;
        end else if (c == CH_LF) begin
          mode_v = M_IDLE;
          if (line_v < LINE_MAX) line_v = line_v + 24'd1;
          res_v[n] = mk(EV_DONE, K_NEWLINE, 8'd0, 12'd0, line_v, ERR_NONE);
          n = n + 2'd1;
        end
      end
      M_STRING, M_ESCAPE: begin
        if (end_of_input) begin
          res_v[n] = mk(EV_DONE, K_ERROR, 8'd0, 12'd0, line_v, ERR_EOF_STRING);
          n = n + 2'd1;
          res_v[n] = mk(EV_END, K_NEWLINE, 8'd0, 12'd0, line_v, ERR_NONE);
          n = n + 2'd1;
          mode_v = M_IDLE;
          tc_v   = 12'd0;
        end else if ((cur.mode == M_STRING) && (c == CH_QUOTE)) begin
          res_v[n] = mk(EV_DONE, K_STRING, 8'd0, tc_v, line_v, ERR_NONE);
          n = n + 2'd1;
          mode_v = M_IDLE;
          tc_v   = 12'd0;
        end else if ((cur.mode == M_STRING) && (c == CH_BSLASH)) begin
          mode_v = M_ESCAPE;
        end else begin
          mode_v = M_STRING;
          ap = do_append(tc_v, cand_v, c, 1'b0, lim);
          res_v[n] = mk(EV_TEXT, K_STRING, c, 12'd0, line_v, ERR_NONE);
          n = n + 2'd1;
          tc_v = ap.tc;
          if (ap.full) begin
            res_v[n] = mk(EV_DONE, K_STRING, 8'd0, tc_v, line_v, ERR_NONE);
            n = n + 2'd1;
            mode_v = M_IDLE;
            tc_v   = 12'd0;
          end
        end
      end
      M_NUMBER: begin
        if (end_of_input || !is_digit) begin
          res_v[n] = mk(EV_DONE, K_NUMBER, 8'd0, tc_v, line_v, ERR_NONE);
          n = n + 2'd1;
          mode_v = M_IDLE;
          tc_v   = 12'd0;
          if (end_of_input) begin
            res_v[n] = mk(EV_END, K_NEWLINE, 8'd0, 12'd0, line_v, ERR_NONE);
            n = n + 2'd1;
          end else begin
            reproc = 1'b1;
          end
        end else begin
          ap = do_append(tc_v, cand_v, c, 1'b0, lim);
          res_v[n] = mk(EV_TEXT, K_NUMBER, c, 12'd0, line_v, ERR_NONE);
          n = n + 2'd1;
          tc_v = ap.tc;
          if (ap.full) begin
            res_v[n] = mk(EV_DONE, K_NUMBER, 8'd0, tc_v, line_v, ERR_NONE);
            n = n + 2'd1;
            mode_v = M_IDLE;
            tc_v   = 12'd0;
          end
        end
      end
      M_NAME: begin
        if (end_of_input || !(is_letter_or_digit || (c == CH_DASH))) begin
          res_v[n] = mk(EV_DONE, name_kind(cand_v, tc_v), 8'd0, tc_v, line_v, ERR_NONE);
          n = n + 2'd1;
          mode_v = M_IDLE;
          tc_v   = 12'd0;
          if (end_of_input) begin
            res_v[n] = mk(EV_END, K_NEWLINE, 8'd0, 12'd0, line_v, ERR_NONE);
            n = n + 2'd1;
          end else begin
            reproc = 1'b1;
          end
        end else begin
          ap = do_append(tc_v, cand_v, c, 1'b1, lim);
          res_v[n] = mk(EV_TEXT, K_NAME, c, 12'd0, line_v, ERR_NONE);
          n = n + 2'd1;
          tc_v   = ap.tc;
          cand_v = ap.cand;
          if (c == CH_DASH) begin
            // A dash that fills the limit can never be followed.
            if (ap.full) begin
              res_v[n] = mk(EV_DONE, K_ERROR, 8'd0, 12'd0, line_v, ERR_DASH);
              n = n + 2'd1;
              mode_v = M_IDLE;
              tc_v   = 12'd0;
            end else begin
              mode_v = M_DASH;
            end
          end else if (ap.full) begin
            res_v[n] = mk(EV_DONE, name_kind(cand_v, tc_v), 8'd0, tc_v, line_v, ERR_NONE);
            n = n + 2'd1;
            mode_v = M_IDLE;
            tc_v   = 12'd0;
          end
        end
      end
      M_DASH: begin
        if (end_of_input || !is_letter_or_digit) begin
          res_v[n] = mk(EV_DONE, K_ERROR, 8'd0, 12'd0, line_v, ERR_DASH);
          n = n + 2'd1;
          mode_v = M_IDLE;
          tc_v   = 12'd0;
          if (end_of_input) begin
            res_v[n] = mk(EV_END, K_NEWLINE, 8'd0, 12'd0, line_v, ERR_NONE);
            n = n + 2'd1;
          end
        end else begin
          mode_v = M_NAME;
          ap = do_append(tc_v, cand_v, c, 1'b1, lim);
          res_v[n] = mk(EV_TEXT, K_NAME, c, 12'd0, line_v, ERR_NONE);
          n = n + 2'd1;
          tc_v   = ap.tc;
          cand_v = ap.cand;
          if (ap.full) begin
            res_v[n] = mk(EV_DONE, name_kind(cand_v, tc_v), 8'd0, tc_v, line_v, ERR_NONE);
            n = n + 2'd1;
            mode_v = M_IDLE;
            tc_v   = 12'd0;
          end
        end
      end
      default: begin
        mode_v = M_IDLE;
        if (end_of_input) begin
          res_v[n] = mk(EV_END, K_NEWLINE, 8'd0, 12'd0, line_v, ERR_NONE);
          n = n + 2'd1;
        end else begin
          reproc = 1'b1;
        end
      end
    endcase

    // Byte seen between tokens, including the byte that ended a token.
    if (reproc) begin
      mode_v = M_IDLE;
      tc_v   = 12'd0;
      if ((c == CH_TAB) || (c == CH_SPACE)) begin
        mode_v = M_IDLE;
      end else if (c == CH_HASH) begin
        mode_v = M_COMMENT;
      end else if (c == CH_LF) begin
        if (line_v < LINE_MAX) line_v = line_v + 24'd1;
        res_v[n] = mk(EV_DONE, K_NEWLINE, 8'd0, 12'd0, line_v, ERR_NONE);
        n = n + 2'd1;
      end else if (c == CH_STAR) begin
        res_v[n] = mk(EV_DONE, K_STAR, 8'd0, 12'd0, line_v, ERR_NONE);
        n = n + 2'd1;
      end else if (c == CH_COMMA) begin
        res_v[n] = mk(EV_DONE, K_COMMA, 8'd0, 12'd0, line_v, ERR_NONE);
        n = n + 2'd1;
      end else if (c == CH_COLON) begin
        res_v[n] = mk(EV_DONE, K_COLON, 8'd0, 12'd0, line_v, ERR_NONE);
        n = n + 2'd1;
      end else if (c == CH_EQUALS) begin
        res_v[n] = mk(EV_DONE, K_EQUALS, 8'd0, 12'd0, line_v, ERR_NONE);
        n = n + 2'd1;
      end else if (c == cfg.open_bracket) begin
        res_v[n] = mk(EV_DONE, K_OPEN, 8'd0, 12'd0, line_v, ERR_NONE);
        n = n + 2'd1;
      end else if (c == cfg.close_bracket) begin
        res_v[n] = mk(EV_DONE, K_CLOSE, 8'd0, 12'd0, line_v, ERR_NONE);
        n = n + 2'd1;
      end else if (c == CH_QUOTE) begin
        mode_v = M_STRING;
      end else if (is_digit) begin
        ap = do_append(tc_v, cand_v, c, 1'b0, lim);
        res_v[n] = mk(EV_TEXT, K_NUMBER, c, 12'd0, line_v, ERR_NONE);
        n = n + 2'd1;
        tc_v   = ap.tc;
        mode_v = M_NUMBER;
        // A leading zero is a whole number by itself.
        if (ap.full || (c == CH_ZERO)) begin
          res_v[n] = mk(EV_DONE, K_NUMBER, 8'd0, tc_v, line_v, ERR_NONE);
          n = n + 2'd1;
          mode_v = M_IDLE;
          tc_v   = 12'd0;
        end
      end else if (is_lower) begin
        ap = do_append(tc_v, {KW_COUNT{1'b1}}, c, 1'b1, lim);
        res_v[n] = mk(EV_TEXT, K_NAME, c, 12'd0, line_v, ERR_NONE);
        n = n + 2'd1;
        tc_v   = ap.tc;
        cand_v = ap.cand;
        mode_v = M_NAME;
        if (ap.full) begin
          res_v[n] = mk(EV_DONE, name_kind(cand_v, tc_v), 8'd0, tc_v, line_v, ERR_NONE);
          n = n + 2'd1;
          mode_v = M_IDLE;
          tc_v   = 12'd0;
        end
      end else begin
        res_v[n] = mk(EV_DONE, K_ERROR, 8'd0, 12'd0, line_v, ERR_BYTE);
        n = n + 2'd1;
      end
    end

    // Mark the final result of this byte.
    for (int i = 0; i < MAX_RES; i++) begin
      if ((n != 2'd0) && (2'(i) == (n - 2'd1))) begin
        res_v[i].last_of_item = 1'b1;
      end
    end
  end

  assign nxt.mode  = mode_v;
  assign nxt.tc    = tc_v;
  assign nxt.line  = line_v;
  assign nxt.cand  = cand_v;
  assign res_count = n;
  assign res       = res_v;

endmodule

@@ rtl/cst_fifo.sv @@
module cst_fifo import cst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_count,
  input  result_t [MAX_RES-1:0] push_data,
  input  logic                  pop,
  output result_t               head,
  output logic                  not_empty,
  output logic                  room
);

  result_t mem [FIFO_DEPTH];

  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW-1:0] count_next;

  assign not_empty = (count != '0);
  // Room for a whole byte's worth of results.
  assign room      = ({{(32-FIFO_CW){1'b0}}, count} <= FIFO_DEPTH - MAX_RES);
  assign head      = mem[rd_ptr];

  assign count_next = count + FIFO_CW'(push_count) - FIFO_CW'(pop && not_empty);

  // Several results enter at consecutive slots in one cycle.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_count) begin
        mem[wr_ptr + FIFO_AW'(i)] <= push_data[i];
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_count);
      if (pop && not_empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    {{(32-FIFO_CW){1'b0}}, count} <= FIFO_DEPTH)
    else $error("result queue fill count beyond its depth");

  a_push_with_room: assert property (@(posedge clk) disable iff (rst)
    (push_count != 2'd0) |-> room)
    else $error("results pushed into a queue without room");

endmodule

@@ rtl/config_spec_tokenizer.sv @@
// Tokenizer for the configuration specification language. It takes one source byte (or an
// end marker) per request on the input channel and delivers result requests on the output
// channel: text characters, token completions and the end event, each with the current line
// number. An accepted byte goes into an input register; once the queue has room, the scanner
// works it out completely, including the byte that ends a number or name, and writes its
// zero to three results into an eight-entry result queue. A new byte is taken in every
// cycle as long as the queue has room for three more results; the output side drains one
// result per cycle while the output is not stalled, so bytes that cause at most one result
// sustain one byte per cycle and the long-run rate is set by the single result port.
// Configuration writes take effect at once and are meant for times when no byte is in
// flight.
module config_spec_tokenizer import cst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_input,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           event_res,
  output logic [4:0]           token_kind,
  output logic [7:0]           text_byte,
  output logic [11:0]          text_length,
  output logic [23:0]          line_number,
  output logic [1:0]           error_code,
  output logic                 last_of_item
);

  cfg_t        cfg;
  scan_state_t state;
  scan_state_t state_next;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_eof;
  logic        accept;
  logic        fire;
  logic        room;

  logic [1:0]            res_count;
  result_t [MAX_RES-1:0] res;
  result_t               head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.token_limit   <= 12'd255;
      cfg.open_bracket  <= 8'h5B;
      cfg.close_bracket <= 8'h5D;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TOKEN_LIMIT:   cfg.token_limit   <= cfg_data;
        CFG_OPEN_BRACKET:  cfg.open_bracket  <= cfg_data[7:0];
        CFG_CLOSE_BRACKET: cfg.close_bracket <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register; it is freed when the scanner consumes it.
  assign fire     = s1_valid && room;
  assign in_stall = s1_valid && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= data_byte;
      s1_eof  <= end_of_input;
    end
  end

  // Scanner state advances once per consumed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode <= M_IDLE;
      state.tc   <= 12'd0;
      state.line <= 24'd1;
      state.cand <= '1;
    end else if (fire) begin
      state <= state_next;
    end
  end

  cst_step u_step (
    .cfg          (cfg),
    .cur          (state),
    .data_byte    (s1_byte),
    .end_of_input (s1_eof),
    .nxt          (state_next),
    .res_count    (res_count),
    .res          (res)
  );

  cst_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (fire ? res_count : 2'd0),
    .push_data  (res),
    .pop        (!out_stall),
    .head       (head),
    .not_empty  (out_valid),
    .room       (room)
  );

  assign event_res    = head.event_res;
  assign token_kind   = head.token_kind;
  assign text_byte    = head.text_byte;
  assign text_length  = head.text_length;
  assign line_number  = head.line_number;
  assign error_code   = head.error_code;
  assign last_of_item = head.last_of_item;

  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !fire) |=> (s1_valid && (s1_byte == $past(s1_byte))
                             && (s1_eof == $past(s1_eof))))
    else $error("waiting input byte lost or changed");

  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_res == EV_END)) |->
      ((token_kind == K_NEWLINE) && (text_length == 12'd0) && last_of_item))
    else $error("end event carries token fields or is not last");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    state.line != 24'd0)
    else $error("line count reached zero");

endmodule

@@ tb/sv/tb_config_spec_tokenizer.sv @@
`timescale 1ns / 100ps

module tb_config_spec_tokenizer;
  import cst_pkg::*;

  // Source characters the scanner treats specially.
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Q = 8'h71;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  localparam int NUM_PHASES   = 8;
  localparam int PHASE_BYTES  = 56;
  localparam int HOLD_CYCLES  = 100;
  localparam int DRAIN_SLACK  = 8;
  localparam int CYCLE_LIMIT  = 300000;

  // Tracks the scanner state and the queue of results each request should cause.
  class token_scoreboard;
    string       kw_names[12];
    result_t     expected_results[$];
    int          errors;
    logic [11:0] limit_reg;
    logic [7:0]  open_reg;
    logic [7:0]  close_reg;
    logic [2:0]  mode;
    int          text_run;
    logic [23:0] line_no;
    logic [11:0] kw_mask;

    function new();
      kw_names = '{"group", "nodes", "node", "attrs", "attr", "value",
                   "number", "from", "to", "match", "ref", "class"};
      errors    = 0;
      limit_reg = 12'd255;
      open_reg  = 8'h5B;
      close_reg = 8'h5D;
      mode      = M_IDLE;
      text_run  = 0;
      line_no   = 24'd1;
      kw_mask   = '1;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_lower(logic [7:0] c);
      return c >= CH_LOWER_A && c <= CH_LOWER_Z;
    endfunction

    function bit is_letter_or_digit(logic [7:0] c);
      return is_digit(c) || is_lower(c);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] value);
      case (idx)
        CFG_TOKEN_LIMIT:   limit_reg = value;
        CFG_OPEN_BRACKET:  open_reg = value[7:0];
        CFG_CLOSE_BRACKET: close_reg = value[7:0];
        default: ;
      endcase
    endfunction

    function void push(logic [1:0] ev, logic [4:0] kind, logic [7:0] b, int len,
                       logic [1:0] err);
      result_t r;
      r.event_res    = ev;
      r.token_kind   = kind;
      r.text_byte    = b;
      r.text_length  = len[11:0];
      r.line_number  = line_no;
      r.error_code   = err;
      r.last_of_item = 1'b0;
      expected_results.push_back(r);
    endfunction

    // A zero limit behaves as one.
    function int token_cap();
      int l;
      l = (limit_reg > LIMIT_MAX) ? LIMIT_MAX : int'(limit_reg);
      return (l == 0) ? 1 : l;
    endfunction

    // Streams one text character and reports whether the token is now full.
    function bit add_char(logic [7:0] c, logic [4:0] kind);
      if (kind == K_NAME)
        for (int k = 0; k < 12; k++)
          if (!(text_run < kw_names[k].len() && kw_names[k][text_run] == c))
            kw_mask[k] = 1'b0;
      push(EV_TEXT, kind, c, 0, ERR_NONE);
      text_run++;
      return text_run >= token_cap();
    endfunction

    function void complete(logic [4:0] kind);
      push(EV_DONE, kind, 8'h00, text_run, ERR_NONE);
      mode     = M_IDLE;
      text_run = 0;
    endfunction

    function void flag_error(logic [1:0] code);
      push(EV_DONE, K_ERROR, 8'h00, 0, code);
      mode     = M_IDLE;
      text_run = 0;
    endfunction

    function void mark_end();
      push(EV_END, K_NEWLINE, 8'h00, 0, ERR_NONE);
    endfunction

    function void count_line();
      if (line_no != LINE_MAX) line_no++;
      push(EV_DONE, K_NEWLINE, 8'h00, 0, ERR_NONE);
    endfunction

    function logic [4:0] name_kind();
      for (int k = 0; k < 12; k++)
        if (kw_mask[k] && kw_names[k].len() == text_run) return K_KEYWORD + 5'(k);
      return K_NAME;
    endfunction

    // Start of a token; punctuation and whitespace win over the bracket bytes.
    function void start_token(logic [7:0] c);
      mode     = M_IDLE;
      text_run = 0;
      if (c == CH_TAB || c == CH_SPACE) begin
      end else if (c == CH_HASH) begin
        mode = M_COMMENT;
      end else if (c == CH_NL) begin
        count_line();
      end else if (c == CH_STAR) begin
        push(EV_DONE, K_STAR, 8'h00, 0, ERR_NONE);
      end else if (c == CH_COMMA) begin
        push(EV_DONE, K_COMMA, 8'h00, 0, ERR_NONE);
      end else if (c == CH_COLON) begin
        push(EV_DONE, K_COLON, 8'h00, 0, ERR_NONE);
      end else if (c == CH_EQUALS) begin
        push(EV_DONE, K_EQUALS, 8'h00, 0, ERR_NONE);
      end else if (c == open_reg) begin
        push(EV_DONE, K_OPEN, 8'h00, 0, ERR_NONE);
      end else if (c == close_reg) begin
        push(EV_DONE, K_CLOSE, 8'h00, 0, ERR_NONE);
      end else if (c == CH_QUOTE) begin
        mode = M_STRING;
      end else if (c == CH_ZERO) begin
        void'(add_char(c, K_NUMBER));
        complete(K_NUMBER);
      end else if (is_digit(c)) begin
        mode = M_NUMBER;
        if (add_char(c, K_NUMBER)) complete(K_NUMBER);
      end else if (is_lower(c)) begin
        kw_mask = '1;
        mode    = M_NAME;
        if (add_char(c, K_NAME)) complete(name_kind());
      end else begin
        flag_error(ERR_BYTE);
      end
    endfunction

    // Works out the results of one accepted request.
    function void note_byte(logic [7:0] b, logic eoi);
      int      first;
      result_t r;
      first = expected_results.size();
      case (mode)
        M_COMMENT: begin
          if (eoi) begin
            mode = M_IDLE;
            mark_end();
          end else if (b == CH_NL) begin
            mode = M_IDLE;
            count_line();
          end
        end
        M_STRING: begin
          if (eoi) begin
            flag_error(ERR_EOF_STRING);
            mark_end();
          end else if (b == CH_QUOTE) complete(K_STRING);
          else if (b == CH_BSLASH) mode = M_ESCAPE;
          else if (add_char(b, K_STRING)) complete(K_STRING);
        end
        M_ESCAPE: begin
          if (eoi) begin
            flag_error(ERR_EOF_STRING);
            mark_end();
          end else begin
            mode = M_STRING;
            if (add_char(b, K_STRING)) complete(K_STRING);
          end
        end
        M_NUMBER: begin
          if (eoi) begin
            complete(K_NUMBER);
            mark_end();
          end else if (is_digit(b)) begin
            if (add_char(b, K_NUMBER)) complete(K_NUMBER);
          end else begin
            complete(K_NUMBER);
            start_token(b);
          end
        end
        M_NAME: begin
          if (eoi) begin
            complete(name_kind());
            mark_end();
          end else if (b == CH_DASH) begin
            if (add_char(b, K_NAME)) flag_error(ERR_DASH);
            else mode = M_DASH;
          end else if (is_letter_or_digit(b)) begin
            if (add_char(b, K_NAME)) complete(name_kind());
          end else begin
            complete(name_kind());
            start_token(b);
          end
        end
        M_DASH: begin
          if (eoi) begin
            flag_error(ERR_DASH);
            mark_end();
          end else if (is_letter_or_digit(b)) begin
            mode = M_NAME;
            if (add_char(b, K_NAME)) complete(name_kind());
          end else flag_error(ERR_DASH);
        end
        default: begin
          mode = M_IDLE;
          if (eoi) mark_end();
          else start_token(b);
        end
      endcase
      if (expected_results.size() > first) begin
        r = expected_results.pop_back();
        r.last_of_item = 1'b1;
        expected_results.push_back(r);
      end
    endfunction

    function void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result with none expected: event %0d kind %0d", got.event_res,
               got.token_kind);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      check_field("event_res", want.event_res, got.event_res);
      check_field("token_kind", want.token_kind, got.token_kind);
      check_field("text_byte", want.text_byte, got.text_byte);
      check_field("text_length", want.text_length, got.text_length);
      check_field("line_number", want.line_number, got.line_number);
      check_field("error_code", want.error_code, got.error_code);
      check_field("last_of_item", want.last_of_item, got.last_of_item);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TOKEN_LIMIT;
  logic [11:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte = '0;
  logic                 end_of_input = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           event_res;
  logic [4:0]           token_kind;
  logic [7:0]           text_byte;
  logic [11:0]          text_length;
  logic [23:0]          line_number;
  logic [1:0]           error_code;
  logic                 last_of_item;

  token_scoreboard sb;
  int idle_pct = 10;
  int sent_count = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  // Register settings per phase, chosen to hit the limit extremes and bracket collisions.
  logic [11:0] limit_plan [NUM_PHASES] = '{12'd1, 12'd0, 12'd3, 12'd4095,
                                           12'd2, 12'd5, 12'd4, 12'd255};
  logic [7:0]  open_plan  [NUM_PHASES] = '{8'h28, 8'h00, 8'h2A, 8'h7B,
                                           8'h22, 8'h61, 8'h35, 8'h20};
  logic [7:0]  close_plan [NUM_PHASES] = '{8'h29, 8'hFF, 8'h0A, 8'h7D,
                                           8'h30, 8'h61, 8'h2D, 8'h23};

  config_spec_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .token_kind   (token_kind),
    .text_byte    (text_byte),
    .text_length  (text_length),
    .line_number  (line_number),
    .error_code   (error_code),
    .last_of_item (last_of_item)
  );

  always #1 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_config_spec_tokenizer: done, errors");
      $finish;
    end
  end

  // Result side: check each accepted request, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({event_res, token_kind, text_byte, text_length, line_number,
                       error_code, last_of_item});
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Offer one byte request, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < idle_pct) begin
      in_valid  <= 1'b0;
      data_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, eoi);
    sent_count++;
  endtask

  // Stop sending and let every expected result come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic load_config(input logic [11:0] limit, input logic [7:0] open_b,
                             input logic [7:0] close_b);
    logic [11:0] open_word;
    logic [11:0] close_word;
    open_word  = {4'($urandom), open_b};
    close_word = {4'($urandom), close_b};
    cfg_write <= 1'b1;
    cfg_index <= CFG_TOKEN_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_index <= CFG_OPEN_BRACKET;
    cfg_data  <= open_word;
    @(posedge clk);
    cfg_index <= CFG_CLOSE_BRACKET;
    cfg_data  <= close_word;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(CFG_TOKEN_LIMIT, limit);
    sb.write_reg(CFG_OPEN_BRACKET, open_word);
    sb.write_reg(CFG_CLOSE_BRACKET, close_word);
  endtask

  function automatic logic [7:0] alnum_byte();
    if ($urandom_range(2) == 0) return 8'($urandom_range(CH_ZERO, CH_NINE));
    return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
  endfunction

  // Mostly well-formed tokens with random content, plus broken ones and noise.
  task automatic send_random_token();
    int          pick;
    int          n;
    logic [7:0]  c;
    string       w;
    pick = $urandom_range(99);
    if (pick < 12) begin
      case ($urandom_range(6))
        0: c = CH_NL;
        1: c = CH_STAR;
        2: c = CH_COMMA;
        3: c = CH_COLON;
        4: c = CH_EQUALS;
        5: c = sb.open_reg;
        default: c = sb.close_reg;
      endcase
      send_byte(c, 1'b0);
    end else if (pick < 20) begin
      repeat ($urandom_range(1, 3)) send_byte($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
    end else if (pick < 26) begin
      // Comment body never holds a newline; it sometimes runs into the end marker.
      send_byte(CH_HASH, 1'b0);
      repeat ($urandom_range(6)) begin
        c = 8'($urandom);
        if (c == CH_NL) c = CH_SPACE;
        send_byte(c, 1'b0);
      end
      if ($urandom_range(4) == 0) send_byte(8'($urandom), 1'b1);
      else send_byte(CH_NL, 1'b0);
    end else if (pick < 42) begin
      // Quoted string with escapes and embedded newlines.
      send_byte(CH_QUOTE, 1'b0);
      repeat ($urandom_range(8)) begin
        n = $urandom_range(9);
        if (n == 0) begin
          send_byte(CH_BSLASH, 1'b0);
          send_byte(8'($urandom), 1'b0);
        end else if (n == 1) begin
          send_byte(CH_NL, 1'b0);
        end else begin
          c = 8'($urandom_range(32, 126));
          if (c == CH_QUOTE || c == CH_BSLASH) c = CH_LOWER_Q;
          send_byte(c, 1'b0);
        end
      end
      if ($urandom_range(9) == 0) send_byte(8'($urandom), 1'b1);
      else send_byte(CH_QUOTE, 1'b0);
    end else if (pick < 54) begin
      if ($urandom_range(4) == 0) begin
        send_byte(CH_ZERO, 1'b0);
      end else begin
        send_byte(8'($urandom_range(CH_ONE, CH_NINE)), 1'b0);
        repeat ($urandom_range(5)) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
      end
    end else if (pick < 78) begin
      // Keywords, keyword prefixes and free-form dashed names.
      n = $urandom_range(9);
      if (n < 6) begin
        w = sb.kw_names[$urandom_range(11)];
        if (n == 5) w = w.substr(0, $urandom_range(w.len() - 1));
        for (int i = 0; i < w.len(); i++) send_byte(w[i], 1'b0);
        if (n == 4) send_byte(alnum_byte(), 1'b0);
      end else begin
        send_byte(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)), 1'b0);
        repeat ($urandom_range(6)) begin
          if ($urandom_range(3) == 0) send_byte(CH_DASH, 1'b0);
          send_byte(alnum_byte(), 1'b0);
        end
      end
      if ($urandom_range(1) == 0) send_byte(CH_SPACE, 1'b0);
    end else if (pick < 84) begin
      // Dash followed by a byte that cannot continue a name, or by the end marker.
      send_byte(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)), 1'b0);
      send_byte(CH_DASH, 1'b0);
      if ($urandom_range(3) == 0) begin
        send_byte(8'($urandom), 1'b1);
      end else begin
        do c = 8'($urandom); while (sb.is_letter_or_digit(c));
        send_byte(c, 1'b0);
      end
    end else if (pick < 94) begin
      send_byte(8'($urandom), 1'b0);
    end else begin
      send_byte(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    string directed_text;
    int    phase_start;
    bit    mid_done;
    directed_text = "attrs node-1 \"\\\"\n\"07\t*,:=[]#z\na-.";
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset settings.
    for (int i = 0; i < directed_text.len(); i++) send_byte(directed_text[i], 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_ONE, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      load_config(limit_plan[ph], open_plan[ph], close_plan[ph]);
      idle_pct = (ph == 5) ? 0 : 10;
      phase_start = sent_count;
      mid_done    = 1'b0;
      while (sent_count - phase_start < PHASE_BYTES) begin
        if (!mid_done && sent_count - phase_start >= PHASE_BYTES / 2) begin
          mid_done = 1'b1;
          if (ph == 1) drain_results();
          else if (ph == 2 || ph == 6) hold_requests++;
        end
        send_random_token();
      end
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("tb_config_spec_tokenizer: done, clean");
    end else begin
      $display("tb_config_spec_tokenizer: done, errors");
    end
    $finish;
  end

endmodule
